// File: hw/rtl/doc_word_stream_to_sjis_text_defines.svh
// Assertion macros used by the checker file dwsj_chk.sv.
`ifndef DOC_WORD_STREAM_TO_SJIS_TEXT_DEFINES_SVH
`define DOC_WORD_STREAM_TO_SJIS_TEXT_DEFINES_SVH

// Check on every clock edge outside reset.
`define DWSJ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define DWSJ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/dwsj_pkg.sv
package dwsj_pkg;

  // Code classes carried in the high byte
  localparam logic [7:0] CodeRaw0    = 8'h00;
  localparam logic [7:0] CodeRaw1    = 8'h01;
  localparam logic [7:0] CodeRaw2    = 8'h02;
  localparam logic [7:0] CodeCtrl    = 8'hC5;
  localparam logic [7:0] CodeNewline = 8'h80;
  localparam logic [7:0] CodePage    = 8'h81;
  localparam logic [7:0] CodeTab     = 8'h82;
  localparam logic [7:0] CodeDecTab  = 8'h83;
  localparam logic [7:0] CodeEnd     = 8'h84;
  localparam logic [7:0] CodeColumn  = 8'h85;
  localparam logic [7:0] CodeCondCol = 8'h86;
  localparam logic [7:0] CodeOddPage = 8'h87;
  localparam logic [7:0] CodeSkip    = 8'hFE;

  // Emitted control bytes
  localparam logic [7:0] ByteLf = 8'h0A;
  localparam logic [7:0] ByteFf = 8'h0C;
  localparam logic [7:0] ByteHt = 8'h09;

  // JIS pair range and Shift-JIS mapping offsets
  localparam logic [7:0] JisMin      = 8'h21;
  localparam logic [7:0] JisMax      = 8'h7F;
  localparam logic [7:0] JisRowSplit = 8'h5E;
  localparam logic [7:0] TrailOddOfs = 8'h1F;
  localparam logic [7:0] TrailGap    = 8'h7F;
  localparam logic [7:0] TrailEvnOfs = 8'h7E;
  localparam logic [7:0] LeadLowOfs  = 8'h70;
  localparam logic [7:0] LeadHighOfs = 8'hB0;

  typedef struct packed {
    logic [7:0] high_byte;
    logic [7:0] low_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_end;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [1:0] count;
    out_t       res0;
    out_t       res1;
    logic       skip_nxt;
    logic       fin_nxt;
  } dec_t;

endpackage

// File: hw/rtl/doc_word_stream_to_sjis_text.sv
// Converts a stream of 16-bit document words into Shift-JIS text bytes. Each
// beat on the input carries one word; each beat on the output carries one text
// byte, or the single end-of-document marker (is_end set, byte zero), with
// last set on the final beat a word produces. A word passes an input register
// and a result register before its first byte is offered on the output. A
// word is accepted every cycle as long as it yields at most one byte and the
// output is not stalled; a JIS pair yields two bytes over the one output
// channel, so a following word that yields bytes waits in the input register
// until the trail byte leaves. Words that yield nothing (skipped, unknown, or
// after the end marker) are absorbed without using an output slot. Skip mode
// toggles on its code word; the end state returns to clear only on reset.
module doc_word_stream_to_sjis_text (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dwsj_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dwsj_pkg::out_t out_data_o
);

  logic          in_vld_q;
  dwsj_pkg::in_t in_q;
  logic          skip_q;
  logic          fin_q;
  dwsj_pkg::dec_t dec;
  logic          space;
  logic          move;
  logic          load;

  dwsj_decode u_decode (
    .word_i     (in_q),
    .skipping_i (skip_q),
    .finished_i (fin_q),
    .dec_o      (dec)
  );

  dwsj_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .dec_i       (dec),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign move       = in_vld_q && ((dec.count == 2'd0) || space);
  assign load       = move && (dec.count != 2'd0);
  assign in_stall_o = in_vld_q && !move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      skip_q   <= 1'b0;
      fin_q    <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (move) begin
        skip_q <= dec.skip_nxt;
        fin_q  <= dec.fin_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

endmodule

// File: hw/rtl/dwsj_decode.sv
module dwsj_decode (
  input  dwsj_pkg::in_t  word_i,
  input  logic           skipping_i,
  input  logic           finished_i,
  output dwsj_pkg::dec_t dec_o
);

  logic [7:0] lo;
  logic [7:0] hi;
  logic [7:0] trail_odd;
  logic [7:0] trail;
  logic [8:0] hi_inc;
  logic [7:0] lead;
  logic       is_pair;

  assign lo = word_i.low_byte;
  assign hi = word_i.high_byte;

  always_comb begin
    trail_odd = lo + dwsj_pkg::TrailOddOfs;
    if (trail_odd >= dwsj_pkg::TrailGap) begin
      trail_odd = trail_odd + 8'd1;
    end
    trail  = hi[0] ? trail_odd : (lo + dwsj_pkg::TrailEvnOfs);
    hi_inc = ({1'b0, hi} + 9'd1) >> 1;
    lead   = hi_inc[7:0] + ((hi <= dwsj_pkg::JisRowSplit) ? dwsj_pkg::LeadLowOfs
                                                          : dwsj_pkg::LeadHighOfs);
  end

  assign is_pair = (lo >= dwsj_pkg::JisMin) && (lo <= dwsj_pkg::JisMax) &&
                   (hi >= dwsj_pkg::JisMin) && (hi <= dwsj_pkg::JisMax);

  always_comb begin
    dec_o          = '0;
    dec_o.skip_nxt = skipping_i;
    dec_o.fin_nxt  = finished_i;
    priority if (finished_i) begin
      dec_o.count = 2'd0;
    end else if (hi == dwsj_pkg::CodeEnd) begin
      dec_o.fin_nxt       = 1'b1;
      dec_o.count         = 2'd1;
      dec_o.res0.out_byte = '0;
      dec_o.res0.is_end   = 1'b1;
      dec_o.res0.last     = 1'b1;
    end else if (skipping_i) begin
      if (hi == dwsj_pkg::CodeSkip) begin
        dec_o.skip_nxt = 1'b0;
      end
    end else begin
      dec_o.res0.last = 1'b1;
      unique case (hi)
        dwsj_pkg::CodeSkip: begin
          dec_o.skip_nxt = 1'b1;
        end
        dwsj_pkg::CodeRaw0, dwsj_pkg::CodeRaw1, dwsj_pkg::CodeRaw2,
        dwsj_pkg::CodeCtrl: begin
          dec_o.count         = 2'd1;
          dec_o.res0.out_byte = lo;
        end
        dwsj_pkg::CodeNewline: begin
          dec_o.count         = 2'd1;
          dec_o.res0.out_byte = dwsj_pkg::ByteLf;
        end
        dwsj_pkg::CodePage, dwsj_pkg::CodeOddPage, dwsj_pkg::CodeColumn,
        dwsj_pkg::CodeCondCol: begin
          dec_o.count         = 2'd1;
          dec_o.res0.out_byte = dwsj_pkg::ByteFf;
        end
        dwsj_pkg::CodeTab, dwsj_pkg::CodeDecTab: begin
          dec_o.count         = 2'd1;
          dec_o.res0.out_byte = dwsj_pkg::ByteHt;
        end
        default: begin
          if (is_pair) begin
            dec_o.count         = 2'd2;
            dec_o.res0.out_byte = lead;
            dec_o.res0.last     = 1'b0;
            dec_o.res1.out_byte = trail;
            dec_o.res1.last     = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/dwsj_outbuf.sv
module dwsj_outbuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  dwsj_pkg::dec_t dec_i,
  output logic           space_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dwsj_pkg::out_t out_data_o
);

  logic [1:0]     cnt_q, cnt_d;
  dwsj_pkg::out_t r0_q, r0_d;
  dwsj_pkg::out_t r1_q, r1_d;
  logic           pop;

  assign pop     = (cnt_q != 2'd0) && !out_stall_i;
  assign space_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_comb begin
    cnt_d = cnt_q;
    r0_d  = r0_q;
    r1_d  = r1_q;
    if (pop) begin
      if (cnt_q == 2'd2) begin
        r0_d  = r1_q;
        cnt_d = 2'd1;
      end else begin
        cnt_d = 2'd0;
      end
    end
    if (load_i) begin
      r0_d  = dec_i.res0;
      r1_d  = dec_i.res1;
      cnt_d = dec_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = r0_q;

endmodule

// File: hw/rtl/dwsj_chk.sv
`include "doc_word_stream_to_sjis_text_defines.svh"

module dwsj_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input dwsj_pkg::out_t out_data_o
);

  logic out_beat;

  assign out_beat = out_valid_o && !out_stall_i;

  `DWSJ_ASSERT_RST(a_idle_in_reset, !rst_ni |-> !out_valid_o, "output valid during reset")
  `DWSJ_ASSERT(a_hold_stalled,
               out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o),
               "stalled beat changed")
  `DWSJ_ASSERT(a_end_shape,
               out_valid_o && out_data_o.is_end |->
                 out_data_o.last && (out_data_o.out_byte == 8'h00),
               "malformed end beat")
  `DWSJ_ASSERT(a_trail_follows,
               out_beat && !out_data_o.last |=>
                 out_valid_o && out_data_o.last && !out_data_o.is_end,
               "trail byte missing")
  `DWSJ_ASSERT(a_quiet_after_end, out_beat && out_data_o.is_end |=> !out_valid_o,
               "output after end of document")

endmodule

bind doc_word_stream_to_sjis_text dwsj_chk u_dwsj_chk (.*);
